// ===== rtl/fpa_pkg.sv =====
// Package for the Q24.8 fixed-point ALU: payload structs, action codes, constants.
// No dependencies; used by every module in rtl/.
package fpa_pkg;

  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PROD_W        = 64;

  localparam logic [DATA_W-1:0] MAX_RAW = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MIN_RAW = 32'h8000_0000;

  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_MIN      = 4'd4,
    ACT_MAX      = 4'd5,
    ACT_INC      = 4'd6,
    ACT_DEC      = 4'd7,
    ACT_INT_PART = 4'd8,
    ACT_FROM_INT = 4'd9
  } fpa_action_e;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] a_operand;
    logic signed [31:0] b_operand;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_raw;
    logic               a_greater;
    logic               a_equal;
    logic               a_less;
    logic               overflowed;
    logic               divide_by_zero;
  } fpa_out_t;

  // Per-transaction control carried along the cell chain
  typedef struct packed {
    logic              is_mul;
    logic              is_div;
    logic              neg;
    logic              a_greater;
    logic              a_equal;
    logic              a_less;
    logic              simple_ovf;
    logic              dbz;
    logic [DATA_W-1:0] simple_res;
    logic [PROD_W-1:0] product;
    logic [DATA_W-1:0] den;
  } fpa_ctl_t;

endpackage

// ===== rtl/fixed_point_q24_8_alu.sv =====
// Q24.8 fixed-point ALU top level: input stage, chain of divider cells, output registers.
// Depends on fpa_pkg, fpa_prep, fpa_div_cell and fpa_post.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries fpa_in_t (action, a_operand,
//   b_operand); output channel out_valid_o/out_ready_i carries fpa_out_t.
//   Every transaction gives exactly one result, in order.
//   From the accepting edge the transaction passes through the input stage
//   register, then one cell per quotient bit (32 + FractionBits cells) and
//   the output register to out_valid_o. Every action takes the same path,
//   so results never overtake each other.
//   Throughput is one transaction per cycle while no stall freezes the
//   chain; the cell chain advances as a whole whenever in_ready_o is high.
//   When the receiver stalls, the result held in the output register waits
//   and one more result is caught in a skid register; only then does
//   in_ready_o drop and the chain freeze. in_ready_o comes from a register.
//   Reset clears all valid bits; in_ready_o is high straight after reset.
module fixed_point_q24_8_alu import fpa_pkg::*; #(
  parameter int unsigned FractionBits = FRACTION_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fpa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fpa_out_t out_data_o
);

  localparam int unsigned NumW = DATA_W + FractionBits;

  logic              en;
  logic              out_free;
  logic              last_valid;
  logic [NumW:0]     stage_valid;
  fpa_ctl_t          stage_ctl [NumW+1];
  logic [DATA_W-1:0] stage_rem [NumW+1];
  logic [NumW-1:0]   stage_qn  [NumW+1];
  fpa_out_t          post_data;
  logic              out_valid_q, skid_valid_q;
  fpa_out_t          out_data_q, skid_data_q;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  fpa_prep #(
    .FractionBits(FractionBits)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .valid_o(stage_valid[0]),
    .ctl_o  (stage_ctl[0]),
    .qn_o   (stage_qn[0])
  );

  assign stage_rem[0] = '0;

  for (genvar g = 0; g < NumW; g++) begin : g_cell
    fpa_div_cell #(
      .FractionBits(FractionBits)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(stage_valid[g]),
      .ctl_i  (stage_ctl[g]),
      .rem_i  (stage_rem[g]),
      .qn_i   (stage_qn[g]),
      .valid_o(stage_valid[g+1]),
      .ctl_o  (stage_ctl[g+1]),
      .rem_o  (stage_rem[g+1]),
      .qn_o   (stage_qn[g+1])
    );
  end

  fpa_post #(
    .FractionBits(FractionBits)
  ) u_post (
    .ctl_i (stage_ctl[NumW]),
    .rem_i (stage_rem[NumW]),
    .qn_i  (stage_qn[NumW]),
    .data_o(post_data)
  );

  assign last_valid = en && stage_valid[NumW];
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || last_valid;
      skid_valid_q <= 1'b0;
    end else if (last_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : post_data;
    end else if (en) begin
      skid_data_q <= post_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/fpa_prep.sv =====
// Input stage: decodes the action, computes simple results, flags, magnitude product and dividend.
// Depends on fpa_pkg.
module fpa_prep import fpa_pkg::*; #(
  parameter int unsigned FractionBits = FRACTION_BITS,
  localparam int unsigned NumW        = DATA_W + FractionBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fpa_in_t         data_i,
  output logic            valid_o,
  output fpa_ctl_t        ctl_o,
  output logic [NumW-1:0] qn_o
);

  function automatic logic [DATA_W:0] sat33(input logic [DATA_W:0] v);
    logic ovf;
    ovf = v[DATA_W] ^ v[DATA_W-1];
    if (ovf) begin
      sat33 = {1'b1, (v[DATA_W] ? MIN_RAW : MAX_RAW)};
    end else begin
      sat33 = {1'b0, v[DATA_W-1:0]};
    end
  endfunction

  logic signed [DATA_W-1:0] a_s, b_s;
  logic [DATA_W-1:0]        a_mag, b_mag;
  logic [DATA_W:0]          a_ext, b_ext;
  logic [DATA_W:0]          sat_sum, sat_diff, sat_inc, sat_dec;
  logic signed [PROD_W-1:0] wide;
  logic                     wide_ovf;
  fpa_ctl_t                 ctl_d, ctl_q;
  logic [NumW-1:0]          qn_d, qn_q;
  logic                     valid_q;

  always_comb begin
    a_s      = data_i.a_operand;
    b_s      = data_i.b_operand;
    a_mag    = a_s[DATA_W-1] ? (32'd0 - a_s) : a_s;
    b_mag    = b_s[DATA_W-1] ? (32'd0 - b_s) : b_s;
    a_ext    = {a_s[DATA_W-1], a_s};
    b_ext    = {b_s[DATA_W-1], b_s};
    sat_sum  = sat33(a_ext + b_ext);
    sat_diff = sat33(a_ext - b_ext);
    sat_inc  = sat33(a_ext + 33'd1);
    sat_dec  = sat33(a_ext - 33'd1);
    wide     = PROD_W'(a_s) <<< FractionBits;
    wide_ovf = wide[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){wide[PROD_W-1]}};

    ctl_d            = '0;
    ctl_d.a_greater  = a_s > b_s;
    ctl_d.a_equal    = a_s == b_s;
    ctl_d.a_less     = a_s < b_s;
    ctl_d.neg        = a_s[DATA_W-1] ^ b_s[DATA_W-1];
    ctl_d.product    = PROD_W'(a_mag) * PROD_W'(b_mag);
    ctl_d.den        = b_mag;

    case (data_i.action)
      ACT_ADD: begin
        {ctl_d.simple_ovf, ctl_d.simple_res} = sat_sum;
      end
      ACT_SUB: begin
        {ctl_d.simple_ovf, ctl_d.simple_res} = sat_diff;
      end
      ACT_MUL: begin
        ctl_d.is_mul = 1'b1;
      end
      ACT_DIV: begin
        if (b_mag == '0) begin
          ctl_d.dbz = 1'b1;
          if (a_s[DATA_W-1]) begin
            ctl_d.simple_res = MIN_RAW;
          end else if (a_mag != '0) begin
            ctl_d.simple_res = MAX_RAW;
          end
        end else begin
          ctl_d.is_div = 1'b1;
        end
      end
      ACT_MIN: begin
        ctl_d.simple_res = ctl_d.a_less ? a_s : b_s;
      end
      ACT_MAX: begin
        ctl_d.simple_res = ctl_d.a_greater ? a_s : b_s;
      end
      ACT_INC: begin
        {ctl_d.simple_ovf, ctl_d.simple_res} = sat_inc;
      end
      ACT_DEC: begin
        {ctl_d.simple_ovf, ctl_d.simple_res} = sat_dec;
      end
      ACT_INT_PART: begin
        ctl_d.simple_res = DATA_W'(a_s >>> FractionBits);
      end
      ACT_FROM_INT: begin
        ctl_d.simple_ovf = wide_ovf;
        if (wide_ovf) begin
          ctl_d.simple_res = wide[PROD_W-1] ? MIN_RAW : MAX_RAW;
        end else begin
          ctl_d.simple_res = wide[DATA_W-1:0];
        end
      end
      default: begin
        ctl_d.simple_res = '0;
      end
    endcase

    qn_d = {a_mag, {FractionBits{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_d;
      qn_q  <= qn_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign qn_o    = qn_q;

endmodule

// ===== rtl/fpa_div_cell.sv =====
// One cell of the divider chain: a restoring step producing one quotient bit.
// Depends on fpa_pkg; other payload passes through unchanged.
module fpa_div_cell import fpa_pkg::*; #(
  parameter int unsigned FractionBits = FRACTION_BITS,
  localparam int unsigned NumW        = DATA_W + FractionBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fpa_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] rem_i,
  input  logic [NumW-1:0]   qn_i,
  output logic              valid_o,
  output fpa_ctl_t          ctl_o,
  output logic [DATA_W-1:0] rem_o,
  output logic [NumW-1:0]   qn_o
);

  logic [DATA_W:0]   r_sh, r_sub;
  logic              ge;
  logic [DATA_W-1:0] rem_d, rem_q;
  logic [NumW-1:0]   qn_d, qn_q;
  fpa_ctl_t          ctl_q;
  logic              valid_q;

  always_comb begin
    r_sh  = {rem_i, qn_i[NumW-1]};
    r_sub = r_sh - {1'b0, ctl_i.den};
    ge    = r_sh >= {1'b0, ctl_i.den};
    rem_d = ge ? r_sub[DATA_W-1:0] : r_sh[DATA_W-1:0];
    qn_d  = {qn_i[NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_i;
      rem_q <= rem_d;
      qn_q  <= qn_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign rem_o   = rem_q;
  assign qn_o    = qn_q;

endmodule

// ===== rtl/fpa_post.sv =====
// Output stage logic: rounds and saturates product and quotient, selects the result.
// Depends on fpa_pkg.
module fpa_post import fpa_pkg::*; #(
  parameter int unsigned FractionBits = FRACTION_BITS,
  localparam int unsigned NumW        = DATA_W + FractionBits
) (
  input  fpa_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] rem_i,
  input  logic [NumW-1:0]   qn_i,
  output fpa_out_t          data_o
);

  localparam logic [PROD_W-1:0] RoundHalf = PROD_W'(1) << (FractionBits - 1);

  function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
    if (neg) begin
      if (mag > PROD_W'(MIN_RAW)) begin
        sat_mag = {1'b1, MIN_RAW};
      end else begin
        sat_mag = {1'b0, 32'd0 - mag[DATA_W-1:0]};
      end
    end else begin
      if (mag > PROD_W'(MAX_RAW)) begin
        sat_mag = {1'b1, MAX_RAW};
      end else begin
        sat_mag = {1'b0, mag[DATA_W-1:0]};
      end
    end
  endfunction

  logic [PROD_W-1:0] mul_mag;
  logic              round_up;
  logic [NumW:0]     div_mag;
  logic [DATA_W:0]   mul_sat, div_sat;

  always_comb begin
    mul_mag  = (ctl_i.product + RoundHalf) >> FractionBits;
    round_up = {rem_i, 1'b0} >= {1'b0, ctl_i.den};
    div_mag  = {1'b0, qn_i} + (NumW+1)'(round_up);
    mul_sat  = sat_mag(ctl_i.neg, mul_mag);
    div_sat  = sat_mag(ctl_i.neg, PROD_W'(div_mag));

    data_o.a_greater      = ctl_i.a_greater;
    data_o.a_equal        = ctl_i.a_equal;
    data_o.a_less         = ctl_i.a_less;
    data_o.divide_by_zero = ctl_i.dbz;
    if (ctl_i.is_mul) begin
      {data_o.overflowed, data_o.result_raw} = mul_sat;
    end else if (ctl_i.is_div) begin
      {data_o.overflowed, data_o.result_raw} = div_sat;
    end else begin
      data_o.overflowed = ctl_i.simple_ovf;
      data_o.result_raw = ctl_i.simple_res;
    end
  end

endmodule

// ===== rtl/fpa_checker.sv =====
// Port-level checker for the fixed-point ALU, bound to the top level below.
// Depends on fpa_pkg.
module fpa_checker import fpa_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input fpa_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({out_data_o.a_greater, out_data_o.a_equal, out_data_o.a_less}))
    else $error("comparison flags not one-hot");

  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.overflowed && out_data_o.divide_by_zero))
    else $error("overflow and divide-by-zero both set");

  a_dbz_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_by_zero |->
      out_data_o.result_raw == '0 || out_data_o.result_raw == MAX_RAW ||
      out_data_o.result_raw == MIN_RAW)
    else $error("divide-by-zero result not saturated or zero");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (.*);
